/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the position servo loop.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/pdsl_pkg.sv */
// Package for the PD position servo loop: widths, reset values and codes.
// Depends on nothing; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package pdsl_pkg;

   localparam int POS_W      = 10;
   localparam int PULSE_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int FRAC_SHIFT = 4;

   localparam logic [POS_W-1:0]   GOAL_RESET    = POS_W'(512);
   localparam logic [PULSE_W-1:0] MAX_PULSE_RST = PULSE_W'(40000);
   localparam logic [PULSE_W-1:0] MID_PULSE_RST = PULSE_W'(3000);

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE     = 2'd0,
      CMD_GOAL       = 2'd1,
      CMD_ENABLE     = 2'd2,
      CMD_GOAL_RESET = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P_FWD = 3'd0,
      REG_GAIN_D_FWD = 3'd1,
      REG_GAIN_P_REV = 3'd2,
      REG_GAIN_D_REV = 3'd3,
      REG_DEADBAND   = 3'd4,
      REG_MIN_PULSE  = 3'd5,
      REG_MAX_PULSE  = 3'd6,
      REG_MID_PULSE  = 3'd7
   } csr_index_type;

   // How the result stage forms the pulse for one sample.
   typedef enum logic [2:0] {
      KIND_OFF = 3'd0,
      KIND_MID = 3'd1,
      KIND_MIN = 3'd2,
      KIND_MAX = 3'd3,
      KIND_PD  = 3'd4
   } kind_type;

endpackage

/* hw/rtl/pdsl_req_if.sv */
// Request channel of the servo loop: valid/ready plus command and value.
// Depends on pdsl_pkg for the field widths.
`timescale 1ns / 1ps

interface pdsl_req_if
   import pdsl_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [POS_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

/* hw/rtl/pdsl_rsp_if.sv */
// Response channel of the servo loop: valid/ready plus drive pulse and enable.
// Depends on pdsl_pkg for the field widths.
`timescale 1ns / 1ps

interface pdsl_rsp_if
   import pdsl_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] drive_pulse;
   logic               drive_on;

   modport source (output valid, output drive_pulse, output drive_on, input ready);
   modport sink   (input valid, input drive_pulse, input drive_on, output ready);
endinterface

/* hw/rtl/pd_position_servo_loop.sv */
// PD position servo loop: one drive pulse per position sample.
// A sample passes the input, product (two gain multipliers) and result registers in turn.
// Throughput: one request per cycle unless the response side stalls the pipeline.
// Each stage takes a new request when it is empty or its content moves on.
// Reset (synchronous, active high): pipeline empty, goal 512, loop disabled, CSR defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pd_position_servo_loop
   import pdsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pdsl_req_if.sink              req,
   pdsl_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ERR_W   = POS_W + 1;
   localparam int PROD_W  = ERR_W + GAIN_W + 1;
   localparam int SUM_W   = PROD_W + 1;
   localparam int CALC_W  = SUM_W + 1;
   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << FRAC_SHIFT) - 1);

   // configuration registers
   logic [GAIN_W-1:0]  gain_p_fwd_ff, gain_d_fwd_ff, gain_p_rev_ff, gain_d_rev_ff;
   logic [POS_W-1:0]   deadband_ff;
   logic [PULSE_W-1:0] min_pulse_ff, max_pulse_ff, mid_pulse_ff;

   // loop state
   logic [POS_W-1:0] goal_ff, goal_in;
   logic [POS_W-1:0] last_ff, last_in;
   logic             moving_up_ff, moving_up_in;
   logic             enabled_ff, enabled_in;

   // input stage
   logic             s1_valid_ff, s1_valid_in;
   cmd_type          s1_cmd_ff;
   logic [POS_W-1:0] s1_value_ff;

   // product stage
   logic                     s2_valid_ff, s2_valid_in;
   kind_type                 s2_kind_ff, s2_kind_in;
   logic signed [PROD_W-1:0] s2_p_prod_ff, s2_p_prod_in;
   logic signed [PROD_W-1:0] s2_d_prod_ff, s2_d_prod_in;

   // result stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PULSE_W-1:0] rsp_pulse_ff, rsp_pulse_in;
   logic               rsp_on_ff;

   logic out_free, s2_free, s1_free, s1_proc;

   logic signed [ERR_W-1:0]  err_s, vel_s;
   logic [ERR_W-1:0]         err_mag;
   logic [GAIN_W-1:0]        p_gain, d_gain;
   logic signed [SUM_W-1:0]  pd_sum, pd_adj;
   logic signed [CALC_W-1:0] pd_raw, pd_hi, pd_lim;
   logic signed [CALC_W-1:0] mid_s, max_s, min_s;

   // handshake: a stage takes new content when empty or when it is emptied now
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s1_proc   = s1_valid_ff && s2_free;
   assign req.ready = s1_free;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.drive_pulse = rsp_pulse_ff;
   assign rsp.drive_on    = rsp_on_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_fwd_ff <= '0;
         gain_d_fwd_ff <= '0;
         gain_p_rev_ff <= '0;
         gain_d_rev_ff <= '0;
         deadband_ff   <= '0;
         min_pulse_ff  <= '0;
         max_pulse_ff  <= MAX_PULSE_RST;
         mid_pulse_ff  <= MID_PULSE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_GAIN_P_FWD: gain_p_fwd_ff <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_D_FWD: gain_d_fwd_ff <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_P_REV: gain_p_rev_ff <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_D_REV: gain_d_rev_ff <= csr_wdata[GAIN_W-1:0];
            REG_DEADBAND:   deadband_ff   <= csr_wdata[POS_W-1:0];
            REG_MIN_PULSE:  min_pulse_ff  <= csr_wdata[PULSE_W-1:0];
            REG_MAX_PULSE:  max_pulse_ff  <= csr_wdata[PULSE_W-1:0];
            REG_MID_PULSE:  mid_pulse_ff  <= csr_wdata[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   // input stage
   assign s1_valid_in = s1_free ? req.valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_cmd_ff   <= cmd_type'(req.command);
         s1_value_ff <= req.value;
      end
   end

   // product stage: command decode, state update, gain products
   assign err_s   = $signed({1'b0, goal_ff}) - $signed({1'b0, s1_value_ff});
   assign vel_s   = $signed({1'b0, last_ff}) - $signed({1'b0, s1_value_ff});
   assign err_mag = err_s[ERR_W-1] ? ERR_W'(-err_s) : ERR_W'(err_s);
   assign p_gain  = moving_up_ff ? gain_p_fwd_ff : gain_p_rev_ff;
   assign d_gain  = moving_up_ff ? gain_d_fwd_ff : gain_d_rev_ff;

   assign s2_p_prod_in = PROD_W'(err_s) * PROD_W'($signed({1'b0, p_gain}));
   assign s2_d_prod_in = PROD_W'(vel_s) * PROD_W'($signed({1'b0, d_gain}));

   always_comb begin
      goal_in      = goal_ff;
      last_in      = last_ff;
      moving_up_in = moving_up_ff;
      enabled_in   = enabled_ff;
      s2_kind_in   = KIND_OFF;
      case (s1_cmd_ff)
         CMD_SAMPLE: begin
            if (!enabled_ff) begin
               s2_kind_in = KIND_OFF;
            end else if (goal_ff == s1_value_ff) begin
               s2_kind_in = KIND_MID;
            end else begin
               last_in = s1_value_ff;
               if (err_mag > {1'b0, deadband_ff}) begin
                  s2_kind_in = err_s[ERR_W-1] ? KIND_MAX : KIND_MIN;
               end else begin
                  s2_kind_in = KIND_PD;
               end
            end
         end
         CMD_GOAL: begin
            moving_up_in = s1_value_ff > goal_ff;
            goal_in      = s1_value_ff;
            enabled_in   = 1'b1;
         end
         CMD_ENABLE: begin
            enabled_in = s1_value_ff[0];
         end
         CMD_GOAL_RESET: begin
            goal_in = GOAL_RESET;
         end
         default: ;
      endcase
   end

   assign s2_valid_in = s2_free ? (s1_valid_ff && (s1_cmd_ff == CMD_SAMPLE)) : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff      <= GOAL_RESET;
         last_ff      <= '0;
         moving_up_ff <= 1'b0;
         enabled_ff   <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (s1_proc) begin
            goal_ff      <= goal_in;
            last_ff      <= last_in;
            moving_up_ff <= moving_up_in;
            enabled_ff   <= enabled_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_kind_ff   <= s2_kind_in;
         s2_p_prod_ff <= s2_p_prod_in;
         s2_d_prod_ff <= s2_d_prod_in;
      end
   end

   // result stage: sum, divide by 16 toward zero, subtract from mid, signed clamp
   assign pd_sum = SUM_W'(s2_p_prod_ff) + SUM_W'(s2_d_prod_ff);
   assign pd_adj = (pd_sum + (pd_sum[SUM_W-1] ? ROUND_BIAS : SUM_W'(0))) >>> FRAC_SHIFT;
   assign mid_s  = $signed({{(CALC_W-PULSE_W){1'b0}}, mid_pulse_ff});
   assign max_s  = $signed({{(CALC_W-PULSE_W){1'b0}}, max_pulse_ff});
   assign min_s  = $signed({{(CALC_W-PULSE_W){1'b0}}, min_pulse_ff});
   assign pd_raw = mid_s - CALC_W'(pd_adj);
   assign pd_hi  = (pd_raw > max_s) ? max_s : pd_raw;
   assign pd_lim = (pd_hi < min_s) ? min_s : pd_hi;

   always_comb begin
      case (s2_kind_ff)
         KIND_OFF: rsp_pulse_in = '0;
         KIND_MID: rsp_pulse_in = mid_pulse_ff;
         KIND_MIN: rsp_pulse_in = min_pulse_ff;
         KIND_MAX: rsp_pulse_in = max_pulse_ff;
         KIND_PD:  rsp_pulse_in = pd_lim[PULSE_W-1:0];
         default:  rsp_pulse_in = '0;
      endcase
   end

   assign rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_pulse_ff <= rsp_pulse_in;
         rsp_on_ff    <= (rsp_pulse_in != '0);
      end
   end

   `ASSERT_IMPLIES(a_on_matches_pulse, clock, reset, rsp_valid_ff, rsp_on_ff == (rsp_pulse_ff != '0))
   `ASSERT_NEXT(a_cmd_no_result, clock, reset, s1_proc && (s1_cmd_ff != CMD_SAMPLE), !s2_valid_ff)
   `ASSERT_NEXT(a_goal_enables, clock, reset, s1_proc && (s1_cmd_ff == CMD_GOAL), enabled_ff)
   `ASSERT_NEXT(a_goal_reset, clock, reset, s1_proc && (s1_cmd_ff == CMD_GOAL_RESET), goal_ff == GOAL_RESET)

endmodule

/* verif/pd_position_servo_loop_tb.sv */
// Self-checking testbench for pd_position_servo_loop: directed table, then random phases.
// Depends on pdsl_pkg, pdsl_req_if, pdsl_rsp_if and the servo loop RTL.
`timescale 1ns / 1ps

module pd_position_servo_loop_tb;
   import pdsl_pkg::*;

   localparam int DRAIN_CYCLES    = 6;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int MAX_REPORTS     = 10;
   localparam longint FRAC_DIV    = longint'(1) << FRAC_SHIFT;

   typedef enum bit {ROW_REG, ROW_REQ} row_kind_type;

   // One line of the directed script: a register write or a request.
   typedef struct {
      row_kind_type       kind;
      logic [2:0]         code;
      logic [15:0]        data;
      bit                 pinned;
      logic [PULSE_W-1:0] pulse;
      bit                 on;
   } row_type;

   typedef struct {
      logic [PULSE_W-1:0] pulse;
      logic               on;
   } drive_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Side-band with the request: a typed-in expectation from the directed table.
   logic               req_pinned;
   logic [PULSE_W-1:0] pin_pulse;
   logic               pin_on;

   pdsl_req_if req_if ();
   pdsl_rsp_if rsp_if ();

   pd_position_servo_loop u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: registers and loop state.
   logic [15:0]      csr_shadow [8];
   logic [POS_W-1:0] track_goal;
   logic [POS_W-1:0] track_last;
   bit               track_up;
   bit               track_enabled;

   drive_type pending [$];

   int mismatches    = 0;
   int accepted      = 0;
   int pulses_seen   = 0;
   int reg_writes    = 0;
   int seen_off      = 0;
   int seen_on_goal  = 0;
   int seen_full     = 0;
   int seen_pd       = 0;
   int req_calm      = 0;
   int rsp_calm      = 0;

   logic [POS_W-1:0] stim_goal;

   row_type script [$] = '{
      '{ROW_REQ, CMD_SAMPLE,     16'd100,   1, 16'd0,     0},
      '{ROW_REQ, CMD_ENABLE,     16'd1,     0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd512,   1, 16'd3000,  1},
      '{ROW_REQ, CMD_SAMPLE,     16'd0,     1, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd1023,  1, 16'd40000, 1},
      '{ROW_REQ, CMD_GOAL,       16'd1023,  0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd1023,  1, 16'd3000,  1},
      '{ROW_REQ, CMD_GOAL_RESET, 16'd0,     0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd512,   1, 16'd3000,  1},
      '{ROW_REQ, CMD_ENABLE,     16'd1022,  0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd600,   1, 16'd0,     0},
      '{ROW_REG, REG_GAIN_P_FWD, 16'd65535, 0, 16'd0,     0},
      '{ROW_REG, REG_GAIN_D_FWD, 16'd65535, 0, 16'd0,     0},
      '{ROW_REG, REG_GAIN_P_REV, 16'd16,    0, 16'd0,     0},
      '{ROW_REG, REG_GAIN_D_REV, 16'd1,     0, 16'd0,     0},
      '{ROW_REG, REG_DEADBAND,   16'd1023,  0, 16'd0,     0},
      '{ROW_REG, REG_MIN_PULSE,  16'd100,   0, 16'd0,     0},
      '{ROW_REG, REG_MAX_PULSE,  16'd65535, 0, 16'd0,     0},
      '{ROW_REG, REG_MID_PULSE,  16'd32768, 0, 16'd0,     0},
      '{ROW_REQ, CMD_GOAL,       16'd900,   0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd899,   0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd0,     0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd1023,  0, 16'd0,     0},
      '{ROW_REQ, CMD_GOAL,       16'd0,     0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd5,     0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd20,    0, 16'd0,     0},
      // min above max: min wins
      '{ROW_REG, REG_MIN_PULSE,  16'd60000, 0, 16'd0,     0},
      '{ROW_REG, REG_MAX_PULSE,  16'd10,    0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd3,     0, 16'd0,     0},
      // zero mid and zero gains: a computed zero switches the drive off
      '{ROW_REG, REG_MIN_PULSE,  16'd0,     0, 16'd0,     0},
      '{ROW_REG, REG_MAX_PULSE,  16'd65535, 0, 16'd0,     0},
      '{ROW_REG, REG_MID_PULSE,  16'd0,     0, 16'd0,     0},
      '{ROW_REG, REG_GAIN_P_REV, 16'd0,     0, 16'd0,     0},
      '{ROW_REG, REG_GAIN_D_REV, 16'd0,     0, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd3,     1, 16'd0,     0},
      '{ROW_REQ, CMD_SAMPLE,     16'd0,     1, 16'd0,     0}
   };

   // Advance the shadow loop by one request; report the pulse a sample produces.
   function automatic void servo_step(input cmd_type cmd, input logic [POS_W-1:0] val,
                                      output bit produced, output logic [PULSE_W-1:0] pulse);
      longint err;
      longint vel;
      longint adj;
      longint level;
      longint band;
      logic [GAIN_W-1:0] p_gain;
      logic [GAIN_W-1:0] d_gain;
      produced = 1'b0;
      pulse    = '0;
      case (cmd)
         CMD_SAMPLE: begin
            produced = 1'b1;
            if (!track_enabled) begin
               seen_off++;
            end else if (val == track_goal) begin
               // hold position: last sample stays as it was
               pulse = csr_shadow[REG_MID_PULSE];
               seen_on_goal++;
            end else begin
               err        = longint'(track_goal) - longint'(val);
               vel        = longint'(track_last) - longint'(val);
               track_last = val;
               p_gain = track_up ? csr_shadow[REG_GAIN_P_FWD] : csr_shadow[REG_GAIN_P_REV];
               d_gain = track_up ? csr_shadow[REG_GAIN_D_FWD] : csr_shadow[REG_GAIN_D_REV];
               band   = longint'(csr_shadow[REG_DEADBAND][POS_W-1:0]);
               if (err > band || err < -band) begin
                  pulse = (err > 0) ? csr_shadow[REG_MIN_PULSE] : csr_shadow[REG_MAX_PULSE];
                  seen_full++;
               end else begin
                  adj = err * longint'(p_gain) + vel * longint'(d_gain);
                  // signed division truncates toward zero
                  adj   = adj / FRAC_DIV;
                  level = longint'(csr_shadow[REG_MID_PULSE]) - adj;
                  if (level > longint'(csr_shadow[REG_MAX_PULSE]))
                     level = longint'(csr_shadow[REG_MAX_PULSE]);
                  if (level < longint'(csr_shadow[REG_MIN_PULSE]))
                     level = longint'(csr_shadow[REG_MIN_PULSE]);
                  pulse = level[PULSE_W-1:0];
                  seen_pd++;
               end
            end
         end
         CMD_GOAL: begin
            track_up      = (val > track_goal);
            track_goal    = val;
            track_enabled = 1'b1;
         end
         CMD_ENABLE: begin
            track_enabled = val[0];
         end
         default: begin
            track_goal = GOAL_RESET;
         end
      endcase
   endfunction

   function automatic void log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%s", msg);
   endfunction

   // Per-item wait, with occasional stretches of back-to-back traffic.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   function automatic logic [15:0] pick_level();
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_request(input cmd_type cmd, input logic [POS_W-1:0] val,
                               input bit pinned = 1'b0,
                               input logic [PULSE_W-1:0] pulse = '0, input bit on = 1'b0);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.value   <= val;
      req_pinned     <= pinned;
      pin_pulse      <= pulse;
      pin_on         <= on;
      if (cmd == CMD_GOAL)
         stim_goal = val;
      else if (cmd == CMD_GOAL_RESET)
         stim_goal = GOAL_RESET;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Write a register once every request in flight has drained.
   task automatic write_reg(input csr_index_type idx, input logic [15:0] data);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en       <= 1'b1;
      csr_index       <= idx;
      csr_wdata       <= data;
      csr_shadow[idx]  = data;
      reg_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      bit                 produced;
      logic [PULSE_W-1:0] pulse;
      drive_type          want;
      if (!reset) begin
         // check the response side first so a same-edge request cannot match itself
         if (rsp_if.valid && rsp_if.ready) begin
            pulses_seen++;
            if (pending.size() == 0) begin
               log_mismatch($sformatf("unexpected response: pulse %0d on %0b",
                                      rsp_if.drive_pulse, rsp_if.drive_on));
            end else begin
               want = pending.pop_front();
               if (rsp_if.drive_pulse !== want.pulse || rsp_if.drive_on !== want.on)
                  log_mismatch($sformatf(
                     "response %0d: expected pulse %0d on %0b, got pulse %0d on %0b",
                     pulses_seen, want.pulse, want.on, rsp_if.drive_pulse, rsp_if.drive_on));
            end
         end
         if (req_if.valid && req_if.ready) begin
            accepted++;
            servo_step(cmd_type'(req_if.command), req_if.value, produced, pulse);
            if (produced) begin
               if (req_pinned) begin
                  want.pulse = pin_pulse;
                  want.on    = pin_on;
               end else begin
                  want.pulse = pulse;
                  want.on    = (pulse != '0);
               end
               pending.push_back(want);
            end
         end
      end
   end

   initial begin : rsp_sink
      int hold;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         hold = draw_gap(rsp_calm);
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   initial begin : stimulus
      logic [15:0]      vals [8];
      logic [POS_W-1:0] v;
      int               r;
      int               span;
      int               t;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.command <= CMD_SAMPLE;
      req_if.value   <= '0;
      req_pinned     <= 1'b0;
      pin_pulse      <= '0;
      pin_on         <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_index      <= REG_GAIN_P_FWD;
      csr_wdata      <= '0;

      foreach (csr_shadow[i]) csr_shadow[i] = '0;
      csr_shadow[REG_MAX_PULSE] = MAX_PULSE_RST;
      csr_shadow[REG_MID_PULSE] = MID_PULSE_RST;
      track_goal    = GOAL_RESET;
      track_last    = '0;
      track_up      = 1'b0;
      track_enabled = 1'b0;
      stim_goal     = GOAL_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_REG)
            write_reg(csr_index_type'(script[i].code), script[i].data);
         else
            send_request(cmd_type'(script[i].code[CMD_W-1:0]), script[i].data[POS_W-1:0],
                         script[i].pinned, script[i].pulse, script[i].on);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               vals = '{default: 16'hFFFF};
               vals[REG_DEADBAND]  = 16'd1023;
               vals[REG_MIN_PULSE] = 16'd0;
            end
            1: vals = '{default: 16'h0000};
            default: begin
               vals[REG_GAIN_P_FWD] = ($urandom_range(0, 3) == 0) ? pick_level()
                                                                  : 16'($urandom_range(0, 96));
               vals[REG_GAIN_D_FWD] = ($urandom_range(0, 3) == 0) ? pick_level()
                                                                  : 16'($urandom_range(0, 96));
               vals[REG_GAIN_P_REV] = ($urandom_range(0, 3) == 0) ? pick_level()
                                                                  : 16'($urandom_range(0, 96));
               vals[REG_GAIN_D_REV] = ($urandom_range(0, 3) == 0) ? pick_level()
                                                                  : 16'($urandom_range(0, 96));
               case ($urandom_range(0, 4))
                  0:       vals[REG_DEADBAND] = 16'd0;
                  1:       vals[REG_DEADBAND] = 16'd1023;
                  2:       vals[REG_DEADBAND] = 16'($urandom_range(1, 15));
                  default: vals[REG_DEADBAND] = 16'($urandom_range(16, 400));
               endcase
               if ($urandom_range(0, 3) == 0) begin
                  // unordered limits, min may end up above max
                  vals[REG_MIN_PULSE] = pick_level();
                  vals[REG_MAX_PULSE] = pick_level();
                  vals[REG_MID_PULSE] = pick_level();
               end else begin
                  vals[REG_MIN_PULSE] = 16'($urandom_range(0, 20000));
                  vals[REG_MAX_PULSE] = 16'($urandom_range(40000, 65535));
                  vals[REG_MID_PULSE] = 16'($urandom_range(vals[REG_MIN_PULSE],
                                                           vals[REG_MAX_PULSE]));
               end
            end
         endcase
         for (int i = 0; i < 8; i++)
            write_reg(csr_index_type'(i), vals[i]);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               // keep most samples near the goal so the PD path is reached
               span = (csr_shadow[REG_DEADBAND] < 40) ? int'(csr_shadow[REG_DEADBAND]) + 2 : 40;
               case ($urandom_range(0, 7))
                  0:       v = stim_goal;
                  1, 2:    v = POS_W'($urandom_range(0, 1023));
                  default: begin
                     t = int'(stim_goal) + int'($urandom_range(0, 2 * span)) - span;
                     if (t < 0)    t = 0;
                     if (t > 1023) t = 1023;
                     v = POS_W'(t);
                  end
               endcase
               send_request(CMD_SAMPLE, v);
            end else if (r < 80) begin
               send_request(CMD_GOAL, POS_W'($urandom_range(0, 1023)));
            end else if (r < 90) begin
               v = POS_W'($urandom_range(0, 1023));
               if ($urandom_range(0, 3) != 0) v[0] = 1'b1;
               send_request(CMD_ENABLE, v);
            end else begin
               send_request(CMD_GOAL_RESET, POS_W'($urandom_range(0, 1023)));
            end
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests over %0d register writes; %0d drive pulses came back.",
               accepted, reg_writes, pulses_seen);
      $display("Pulse paths: %0d loop off, %0d on goal, %0d full drive, %0d PD term.",
               seen_off, seen_on_goal, seen_full, seen_pd);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("timeout: run did not complete, %0d responses still due", pending.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
